@@ rtl/cle_pkg.sv @@
// Package: character codes, result bundle and status types for the comment extractor.
package cle_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int MAX_RESULTS = 3;

  typedef logic [1:0] count_t;

  typedef struct packed {
    count_t     count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } bundle_t;

  typedef struct packed {
    logic in_line_comment;
    logic held_valid;
    logic in_single_quote;
    logic in_double_quote;
  } status_t;

endpackage

@@ rtl/cle_ifs.sv @@
// Interfaces: character input channel and comment output channel.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, output in_byte, output line_end, input ready);
  modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

@@ rtl/c_line_comment_extractor_unit.sv @@
// Top level: C line-comment extractor with one-byte lookahead and result register.
// Results of a transaction are registered and appear in the cycle after it is accepted.
// Throughput: one input per cycle when each yields at most one result and the output is
// ready; an input yielding several results stalls input until its last result is taken.
// Reset (rst, synchronous): clears all context, drops the lookahead byte and
// empties the result register; the next byte is taken as the start of a line.
module c_line_comment_extractor_unit (
  input  logic      clk,
  input  logic      rst,
  cle_in_if.sink    chars,
  cle_out_if.source comments
);

  cle_pkg::bundle_t bundle;
  cle_pkg::status_t status;
  logic             can_load;
  logic             accept;

  assign chars.ready = can_load;
  assign accept      = chars.valid && chars.ready;

  cle_step u_step (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (chars.in_byte),
    .line_end (chars.line_end),
    .bundle   (bundle),
    .status   (status)
  );

  cle_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .bundle   (bundle),
    .can_load (can_load),
    .dst      (comments)
  );

  a_line_no_held: assert property (@(posedge clk) disable iff (rst)
    !(status.in_line_comment && status.held_valid))
    else $error("line comment active with a held byte");

  a_quotes_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.in_single_quote && status.in_double_quote))
    else $error("both quote flags set");

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> comments.valid && !comments.run_last || !comments.ready)
    else $error("input stalled without pending results");

  a_multi_result_follow: assert property (@(posedge clk) disable iff (rst)
    comments.valid && comments.ready && !comments.run_last |=> comments.valid)
    else $error("transaction results broken apart");

endmodule

@@ rtl/cle_step.sv @@
// Context tracking and per-transaction result bundle generation.
module cle_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             line_end,
  output cle_pkg::bundle_t bundle,
  output cle_pkg::status_t status
);

  logic       in_block_comment, in_block_comment_next;
  logic       in_line_comment, in_line_comment_next;
  logic       in_single_quote, in_single_quote_next;
  logic       in_double_quote, in_double_quote_next;
  logic       held_valid, held_valid_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_at_line_start, held_at_line_start_next;
  logic [7:0] byte_before_held, byte_before_held_next;
  logic [7:0] previous_byte;
  logic       at_line_start, at_line_start_next;
  logic       quiet;
  logic       no_escape;

  always_comb begin
    in_block_comment_next   = in_block_comment;
    in_line_comment_next    = in_line_comment;
    in_single_quote_next    = in_single_quote;
    in_double_quote_next    = in_double_quote;
    held_valid_next         = held_valid;
    held_byte_next          = held_byte;
    held_at_line_start_next = held_at_line_start;
    byte_before_held_next   = byte_before_held;
    at_line_start_next      = at_line_start;
    bundle.count            = '0;
    bundle.b0               = in_byte;
    bundle.b1               = cle_pkg::CH_SLASH;
    bundle.b2               = in_byte;
    quiet     = !in_single_quote && !in_double_quote && !in_block_comment;
    no_escape = byte_before_held != cle_pkg::CH_BSLASH;

    if (in_line_comment) begin
      bundle.count = 2'd1;
    end else if (held_valid) begin
      held_valid_next = 1'b0;
      if (held_byte == cle_pkg::CH_SLASH && in_byte == cle_pkg::CH_STAR && quiet) begin
        in_block_comment_next = 1'b1;
      end else if (held_byte == cle_pkg::CH_STAR && in_byte == cle_pkg::CH_SLASH) begin
        in_block_comment_next = 1'b0;
      end else if (held_byte == cle_pkg::CH_SLASH && in_byte == cle_pkg::CH_SLASH && quiet) begin
        in_line_comment_next = 1'b1;
        bundle.count         = line_end ? 2'd3 : 2'd2;
        bundle.b0            = cle_pkg::CH_SLASH;
      end else begin
        if (held_byte == cle_pkg::CH_DQUOTE && !in_block_comment &&
            (held_at_line_start || (no_escape && !in_single_quote))) begin
          in_double_quote_next = !in_double_quote;
        end
        if (held_byte == cle_pkg::CH_SQUOTE && !in_block_comment &&
            (held_at_line_start || (no_escape && !in_double_quote))) begin
          in_single_quote_next = !in_single_quote;
        end
        if (!line_end) begin
          held_valid_next         = 1'b1;
          held_byte_next          = in_byte;
          held_at_line_start_next = at_line_start;
          byte_before_held_next   = previous_byte;
        end
      end
    end else if (!line_end) begin
      held_valid_next         = 1'b1;
      held_byte_next          = in_byte;
      held_at_line_start_next = at_line_start;
      byte_before_held_next   = previous_byte;
    end

    if (line_end) begin
      in_line_comment_next = 1'b0;
      in_single_quote_next = 1'b0;
      in_double_quote_next = 1'b0;
      held_valid_next      = 1'b0;
      at_line_start_next   = 1'b1;
    end else begin
      at_line_start_next = 1'b0;
    end

    if (!accept) begin
      bundle.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_block_comment   <= 1'b0;
      in_line_comment    <= 1'b0;
      in_single_quote    <= 1'b0;
      in_double_quote    <= 1'b0;
      held_valid         <= 1'b0;
      held_byte          <= '0;
      held_at_line_start <= 1'b0;
      byte_before_held   <= '0;
      previous_byte      <= '0;
      at_line_start      <= 1'b1;
    end else if (accept) begin
      in_block_comment   <= in_block_comment_next;
      in_line_comment    <= in_line_comment_next;
      in_single_quote    <= in_single_quote_next;
      in_double_quote    <= in_double_quote_next;
      held_valid         <= held_valid_next;
      held_byte          <= held_byte_next;
      held_at_line_start <= held_at_line_start_next;
      byte_before_held   <= byte_before_held_next;
      previous_byte      <= in_byte;
      at_line_start      <= at_line_start_next;
    end
  end

  assign status.in_line_comment = in_line_comment;
  assign status.held_valid      = held_valid;
  assign status.in_single_quote = in_single_quote;
  assign status.in_double_quote = in_double_quote;

endmodule

@@ rtl/cle_outbuf.sv @@
// Result register: up to three bytes of one transaction, drained one per cycle when ready.
module cle_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cle_pkg::bundle_t bundle,
  output logic             can_load,
  cle_out_if.source        dst
);

  cle_pkg::count_t remaining;
  logic [7:0]      slot [cle_pkg::MAX_RESULTS];
  logic            take;

  assign take     = dst.valid && dst.ready;
  assign can_load = (remaining == 2'd0) || (remaining == 2'd1 && dst.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= bundle.count;
    end else if (take) begin
      remaining <= remaining - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= bundle.b0;
      slot[1] <= bundle.b1;
      slot[2] <= bundle.b2;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign dst.valid    = remaining != 2'd0;
  assign dst.out_byte = slot[0];
  assign dst.run_last = remaining == 2'd1;

endmodule
